/* rtl/spectral_peak_note_and_beat_detector_assert.svh */
// Assertion macros shared by the detector modules.
// Each check is disabled while the synchronous reset is low.
`ifndef SPECTRAL_PEAK_NOTE_AND_BEAT_DETECTOR_ASSERT_SVH
`define SPECTRAL_PEAK_NOTE_AND_BEAT_DETECTOR_ASSERT_SVH

// Same-cycle implication.
`define SPNBD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SPNBD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/spnbd_pkg.sv */
package spnbd_pkg;

    localparam int NUM_BINS      = 512;
    localparam int MAG_FRAC_BITS = 8;

    localparam int BIN_W   = 9;
    localparam int MAG_W   = 16;
    localparam int SUM_W   = 25;
    localparam int CHG_W   = SUM_W + 1;
    localparam int THR_W   = 24;
    localparam int TALLY_W = 16;
    localparam int NOTE_W  = 4;

    localparam int NUM_NOTES   = 12;
    localparam int NUM_OCTAVES = 3;

    localparam int QPTR_W      = 2;
    localparam int QUEUE_DEPTH = 1 << QPTR_W;
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [BIN_W-1:0]   LAST_POS  = BIN_W'(NUM_BINS - 1);
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};
    localparam logic [THR_W-1:0]   THR_RESET = THR_W'(1 << MAG_FRAC_BITS);

    localparam logic CMD_BIN  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [BIN_W-1:0] NOTE_BINS [NUM_NOTES][NUM_OCTAVES] = '{
        '{9'd98,  9'd49, 9'd24}, '{9'd103, 9'd52, 9'd26}, '{9'd110, 9'd55, 9'd27},
        '{9'd116, 9'd58, 9'd29}, '{9'd123, 9'd61, 9'd31}, '{9'd131, 9'd65, 9'd32},
        '{9'd139, 9'd69, 9'd34}, '{9'd147, 9'd73, 9'd36}, '{9'd156, 9'd77, 9'd39},
        '{9'd165, 9'd82, 9'd41}, '{9'd175, 9'd87, 9'd43}, '{9'd186, 9'd92, 9'd46}
    };

    // Record handed from front to back: a closed frame or a tick.
    typedef struct packed {
        logic             kind;
        logic [BIN_W-1:0] peak_idx;
        logic [BIN_W-1:0] runner_idx;
        logic [SUM_W-1:0] energy;
    } t_frame_rec;

    typedef struct packed {
        logic              hit;
        logic [NOTE_W-1:0] note;
    } t_note_hit;

    function automatic t_note_hit note_lookup(input logic [BIN_W-1:0] bin);
        t_note_hit res;
        res.hit  = 1'b0;
        res.note = '0;
        for (int n = 0; n < NUM_NOTES; n++) begin
            for (int k = 0; k < NUM_OCTAVES; k++) begin
                if (bin == NOTE_BINS[n][k]) begin
                    res.hit  = 1'b1;
                    res.note = NOTE_W'(n);
                end
            end
        end
        return res;
    endfunction

endpackage

/* rtl/spnbd_front.sv */
module spnbd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_cmd,
    input  logic [spnbd_pkg::MAG_W-1:0]    i_magnitude,
    input  logic                           i_last_bin,
    input  logic                           i_q_full,
    output logic                           o_stall,
    output logic                           o_push,
    output spnbd_pkg::t_frame_rec          o_rec
);
    import spnbd_pkg::*;

    logic [BIN_W-1:0] r_bin_pos,   n_bin_pos;
    logic [BIN_W-1:0] r_peak_idx,  n_peak_idx;
    logic [MAG_W-1:0] r_peak_val,  n_peak_val;
    logic             r_peak_vld,  n_peak_vld;
    logic [BIN_W-1:0] r_runner,    n_runner;
    logic [SUM_W-1:0] r_energy,    n_energy;

    logic             accept;
    logic             take;
    logic [BIN_W-1:0] upd_peak_idx;
    logic [BIN_W-1:0] upd_runner;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] upd_energy;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    // Ties go to the later bin.
    assign take         = !r_peak_vld || (i_magnitude >= r_peak_val);
    assign upd_peak_idx = take ? r_bin_pos  : r_peak_idx;
    assign upd_runner   = take ? r_peak_idx : r_runner;
    assign sum_wide     = {1'b0, r_energy} + (SUM_W + 1)'(i_magnitude);
    assign upd_energy   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    always_comb begin
        n_bin_pos  = r_bin_pos;
        n_peak_idx = r_peak_idx;
        n_peak_val = r_peak_val;
        n_peak_vld = r_peak_vld;
        n_runner   = r_runner;
        n_energy   = r_energy;
        if (accept && (i_cmd == CMD_BIN)) begin
            if (i_last_bin) begin
                n_bin_pos  = '0;
                n_peak_idx = '0;
                n_peak_vld = 1'b0;
                n_runner   = '0;
                n_energy   = '0;
            end else begin
                n_bin_pos  = (r_bin_pos == LAST_POS) ? '0 : r_bin_pos + BIN_W'(1);
                n_peak_idx = upd_peak_idx;
                n_runner   = upd_runner;
                n_energy   = upd_energy;
                if (take) begin
                    n_peak_val = i_magnitude;
                    n_peak_vld = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_pos  <= '0;
            r_peak_idx <= '0;
            r_peak_val <= '0;
            r_peak_vld <= 1'b0;
            r_runner   <= '0;
            r_energy   <= '0;
        end else begin
            r_bin_pos  <= n_bin_pos;
            r_peak_idx <= n_peak_idx;
            r_peak_val <= n_peak_val;
            r_peak_vld <= n_peak_vld;
            r_runner   <= n_runner;
            r_energy   <= n_energy;
        end
    end

    // Forward only items that produce a result.
    assign o_push = accept && ((i_cmd == CMD_TICK) || i_last_bin);

    always_comb begin
        o_rec.kind       = (i_cmd == CMD_TICK) ? KIND_TICK : KIND_FRAME;
        o_rec.peak_idx   = upd_peak_idx;
        o_rec.runner_idx = upd_runner;
        o_rec.energy     = upd_energy;
    end

endmodule

/* rtl/spnbd_queue.sv */
`include "spectral_peak_note_and_beat_detector_assert.svh"

module spnbd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  spnbd_pkg::t_frame_rec i_rec,
    input  logic                  i_pop,
    output spnbd_pkg::t_frame_rec o_rec,
    output logic                  o_empty,
    output logic                  o_full
);
    import spnbd_pkg::*;

    t_frame_rec        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_rec   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `SPNBD_ASSERT_IMP(a_push_room, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `SPNBD_ASSERT_IMP(a_pop_data, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")
    `SPNBD_ASSERT_NXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + QCNT_W'(1), "queue count did not advance")

endmodule

/* rtl/spnbd_back.sv */
`include "spectral_peak_note_and_beat_detector_assert.svh"

module spnbd_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [spnbd_pkg::THR_W-1:0]     i_cfg_data,
    input  spnbd_pkg::t_frame_rec           i_rec,
    input  logic                            i_q_empty,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_kind,
    output logic                            o_note_updated,
    output logic [spnbd_pkg::NOTE_W-1:0]    o_note,
    output logic                            o_note_seen,
    output logic [spnbd_pkg::BIN_W-1:0]     o_peak_bin,
    output logic [spnbd_pkg::TALLY_W-1:0]   o_beat_count
);
    import spnbd_pkg::*;

    logic [THR_W-1:0]        r_thr;
    logic [SUM_W-1:0]        r_prev_sum,   n_prev_sum;
    logic signed [CHG_W-1:0] r_prev_chg,   n_prev_chg;
    logic [TALLY_W-1:0]      r_tally,      n_tally;
    logic [NOTE_W-1:0]       r_held_note,  n_held_note;
    logic                    r_held_valid, n_held_valid;

    logic                    r_out_valid;
    logic                    r_out_kind;
    logic                    r_out_upd;
    logic [NOTE_W-1:0]       r_out_note;
    logic                    r_out_seen;
    logic [BIN_W-1:0]        r_out_peak;
    logic [TALLY_W-1:0]      r_out_beat;

    logic                    n_upd;
    logic signed [CHG_W-1:0] change;
    logic [CHG_W-1:0]        abs_chg;
    logic [CHG_W-1:0]        abs_prev;
    logic                    chg_pos, chg_neg, prev_pos, prev_neg;
    logic                    flip, swing_big;
    logic                    not_adjacent;
    logic [BIN_W:0]          pk_ext, rn_ext;
    t_note_hit               hit;

    // Take a record whenever the output register is free or being drained.
    assign o_pop = !i_q_empty && (!r_out_valid || !i_stall);

    assign change   = $signed({1'b0, i_rec.energy}) - $signed({1'b0, r_prev_sum});
    assign abs_chg  = change[CHG_W-1] ? CHG_W'(-change) : CHG_W'(change);
    assign abs_prev = r_prev_chg[CHG_W-1] ? CHG_W'(-r_prev_chg) : CHG_W'(r_prev_chg);
    assign chg_neg  = change[CHG_W-1];
    assign chg_pos  = !change[CHG_W-1] && (change != '0);
    assign prev_neg = r_prev_chg[CHG_W-1];
    assign prev_pos = !r_prev_chg[CHG_W-1] && (r_prev_chg != '0);
    assign flip     = (prev_neg && chg_pos) || (prev_pos && chg_neg);
    assign swing_big = (abs_prev > CHG_W'(r_thr)) && (abs_chg > CHG_W'(r_thr));

    // Neighbours compared without wrap at either edge.
    assign pk_ext       = {1'b0, i_rec.peak_idx};
    assign rn_ext       = {1'b0, i_rec.runner_idx};
    assign not_adjacent = (rn_ext != pk_ext) && (rn_ext != pk_ext + (BIN_W + 1)'(1))
                          && (rn_ext + (BIN_W + 1)'(1) != pk_ext);
    assign hit          = note_lookup(i_rec.peak_idx);

    always_comb begin
        n_prev_sum   = r_prev_sum;
        n_prev_chg   = r_prev_chg;
        n_tally      = r_tally;
        n_held_note  = r_held_note;
        n_held_valid = r_held_valid;
        n_upd        = 1'b0;
        if (o_pop) begin
            unique case (i_rec.kind)
                KIND_TICK: begin
                    n_tally = '0;
                end
                KIND_FRAME: begin
                    if (flip && swing_big && (r_tally != TALLY_MAX)) begin
                        n_tally = r_tally + TALLY_W'(1);
                    end
                    n_prev_chg = change;
                    n_prev_sum = i_rec.energy;
                    if (not_adjacent && hit.hit) begin
                        n_held_note  = hit.note;
                        n_held_valid = 1'b1;
                        n_upd        = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr        <= THR_RESET;
            r_prev_sum   <= '0;
            r_prev_chg   <= '0;
            r_tally      <= '0;
            r_held_note  <= '0;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            r_prev_sum   <= n_prev_sum;
            r_prev_chg   <= n_prev_chg;
            r_tally      <= n_tally;
            r_held_note  <= n_held_note;
            r_held_valid <= n_held_valid;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload: load on pop, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_kind <= i_rec.kind;
            r_out_upd  <= n_upd;
            r_out_note <= n_held_note;
            r_out_seen <= n_held_valid;
            r_out_peak <= (i_rec.kind == KIND_FRAME) ? i_rec.peak_idx : '0;
            r_out_beat <= (i_rec.kind == KIND_TICK) ? r_tally : '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_note_updated = r_out_upd;
    assign o_note         = r_out_note;
    assign o_note_seen    = r_out_seen;
    assign o_peak_bin     = r_out_peak;
    assign o_beat_count   = r_out_beat;

    `SPNBD_ASSERT_IMP(a_tick_fields, i_clk, i_rst_n, o_valid && (o_kind == KIND_TICK), (o_peak_bin == '0) && !o_note_updated, "tick result carries frame fields")
    `SPNBD_ASSERT_IMP(a_frame_beat, i_clk, i_rst_n, o_valid && (o_kind == KIND_FRAME), o_beat_count == '0, "frame result carries a beat count")
    `SPNBD_ASSERT_NXT(a_seen_sticky, i_clk, i_rst_n, r_held_valid, r_held_valid, "note seen flag dropped")
    `SPNBD_ASSERT_IMP(a_upd_seen, i_clk, i_rst_n, o_valid && o_note_updated, o_note_seen, "note update without note seen")

endmodule

/* rtl/spectral_peak_note_and_beat_detector.sv */
// Channel   Direction  Handshake             Payload
// input     in         i_valid / o_stall     i_cmd, i_magnitude, i_last_bin
// result    out        o_valid / i_stall     o_kind, o_note_updated, o_note, o_note_seen,
//                                            o_peak_bin, o_beat_count
// config    in         i_cfg_we              i_cfg_data (swing threshold)
//
// One item per cycle unless stalled: the front does the bin compare and saturating add in
// the cycle of transfer; a frame end or tick passes the queue, then the result register.
// Four-entry queue between front and back; back drains one record per cycle unless stalled.
// Synchronous active-low reset clears frame, beat and note state; threshold resets to 1.0.
// o_stall rises only when the queue is full; bins that end no frame still wait then.
module spectral_peak_note_and_beat_detector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_cmd,
    input  logic [spnbd_pkg::MAG_W-1:0]     i_magnitude,
    input  logic                            i_last_bin,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_kind,
    output logic                            o_note_updated,
    output logic [spnbd_pkg::NOTE_W-1:0]    o_note,
    output logic                            o_note_seen,
    output logic [spnbd_pkg::BIN_W-1:0]     o_peak_bin,
    output logic [spnbd_pkg::TALLY_W-1:0]   o_beat_count,
    input  logic                            i_cfg_we,
    input  logic [spnbd_pkg::THR_W-1:0]     i_cfg_data
);
    import spnbd_pkg::*;

    logic       q_push, q_pop, q_empty, q_full;
    t_frame_rec push_rec, head_rec;

    spnbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_cmd       (i_cmd),
        .i_magnitude (i_magnitude),
        .i_last_bin  (i_last_bin),
        .i_q_full    (q_full),
        .o_stall     (o_stall),
        .o_push      (q_push),
        .o_rec       (push_rec)
    );

    spnbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (push_rec),
        .i_pop   (q_pop),
        .o_rec   (head_rec),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    spnbd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_rec          (head_rec),
        .i_q_empty      (q_empty),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_note_updated (o_note_updated),
        .o_note         (o_note),
        .o_note_seen    (o_note_seen),
        .o_peak_bin     (o_peak_bin),
        .o_beat_count   (o_beat_count)
    );

endmodule

/* tb/tb_spectral_peak_note_and_beat_detector.sv */
`timescale 1ns / 100ps

module tb_spectral_peak_note_and_beat_detector;
    import spnbd_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 150;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 840;

    typedef struct packed {
        logic               kind;
        logic               note_updated;
        logic [NOTE_W-1:0]  note;
        logic               note_seen;
        logic [BIN_W-1:0]   peak_bin;
        logic [TALLY_W-1:0] beat_count;
    } t_detector_report;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_cmd = CMD_BIN;
    logic [MAG_W-1:0]   i_magnitude = '0;
    logic               i_last_bin = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_kind;
    logic               o_note_updated;
    logic [NOTE_W-1:0]  o_note;
    logic               o_note_seen;
    logic [BIN_W-1:0]   o_peak_bin;
    logic [TALLY_W-1:0] o_beat_count;
    logic               i_cfg_we = 1'b0;
    logic [THR_W-1:0]   i_cfg_data = '0;

    // Predictor state
    logic [THR_W-1:0]         swing_thr = THR_RESET;
    logic [BIN_W-1:0]         bin_pos = '0;
    logic [BIN_W-1:0]         peak_idx = '0;
    logic [BIN_W-1:0]         runner_idx = '0;
    logic [MAG_W-1:0]         peak_mag = '0;
    bit                       peak_live = 1'b0;
    logic [SUM_W-1:0]         frame_energy = '0;
    logic [SUM_W-1:0]         last_energy = '0;
    logic signed [CHG_W-1:0]  last_change = '0;
    logic [TALLY_W-1:0]       beat_tally = '0;
    logic [NOTE_W-1:0]        held_note = '0;
    bit                       note_known = 1'b0;

    t_detector_report pending_reports[$];

    bit quiet = 1'b0;
    bit rx_hold = 1'b0;
    event hold_start;

    int cycle_count = 0;
    int mismatches = 0;
    int items_sent = 0;
    int frames_closed = 0;
    int ticks_sent = 0;
    int note_updates = 0;
    int beats_read = 0;
    int thr_writes = 0;

    spectral_peak_note_and_beat_detector i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_magnitude    (i_magnitude),
        .i_last_bin     (i_last_bin),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_note_updated (o_note_updated),
        .o_note         (o_note),
        .o_note_seen    (o_note_seen),
        .o_peak_bin     (o_peak_bin),
        .o_beat_count   (o_beat_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_reports.size());
            $display("FAIL");
            $finish;
        end
    end

    // Pitch class of a bin, -1 when the bin is not in the table
    function automatic int pitch_class(input int bin);
        case (bin)
            98, 49, 24:  return 0;
            103, 52, 26: return 1;
            110, 55, 27: return 2;
            116, 58, 29: return 3;
            123, 61, 31: return 4;
            131, 65, 32: return 5;
            139, 69, 34: return 6;
            147, 73, 36: return 7;
            156, 77, 39: return 8;
            165, 82, 41: return 9;
            175, 87, 43: return 10;
            186, 92, 46: return 11;
            default:     return -1;
        endcase
    endfunction

    task automatic track_item(input logic cmd, input logic [MAG_W-1:0] mag, input logic last);
        t_detector_report        rep;
        logic [CHG_W-1:0]        acc;
        logic signed [CHG_W-1:0] chg;
        logic [CHG_W-1:0]        prev_abs;
        logic [CHG_W-1:0]        now_abs;
        bit                      flip;
        int                      pk;
        int                      rn;
        int                      pc;
        rep = '0;
        rep.note      = held_note;
        rep.note_seen = note_known;
        if (cmd == CMD_TICK) begin
            rep.kind       = KIND_TICK;
            rep.beat_count = beat_tally;
            beats_read    += beat_tally;
            beat_tally     = '0;
            pending_reports.push_back(rep);
            return;
        end
        // Ties go to the later bin
        if (!peak_live || mag >= peak_mag) begin
            runner_idx = peak_idx;
            peak_idx   = bin_pos;
            peak_mag   = mag;
            peak_live  = 1'b1;
        end
        acc = {1'b0, frame_energy} + CHG_W'(mag);
        frame_energy = (acc > CHG_W'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];
        bin_pos = (bin_pos == BIN_W'(NUM_BINS - 1)) ? '0 : bin_pos + 1'b1;
        if (!last)
            return;

        chg      = $signed({1'b0, frame_energy}) - $signed({1'b0, last_energy});
        flip     = (last_change < 0 && chg > 0) || (last_change > 0 && chg < 0);
        prev_abs = (last_change < 0) ? -last_change : last_change;
        now_abs  = (chg < 0) ? -chg : chg;
        if (flip && prev_abs > CHG_W'(swing_thr) && now_abs > CHG_W'(swing_thr)
                && beat_tally != TALLY_MAX)
            beat_tally = beat_tally + 1'b1;
        last_change  = chg;
        last_energy  = frame_energy;
        frame_energy = '0;

        // Neighbours are compared without wrapping at the ends of the spectrum
        pk = peak_idx;
        rn = runner_idx;
        pc = pitch_class(pk);
        if (rn != pk && rn != pk + 1 && rn != pk - 1 && pc >= 0) begin
            held_note        = NOTE_W'(pc);
            note_known       = 1'b1;
            rep.note_updated = 1'b1;
            note_updates++;
        end
        rep.kind      = KIND_FRAME;
        rep.note      = held_note;
        rep.note_seen = note_known;
        rep.peak_bin  = peak_idx;
        pending_reports.push_back(rep);
        frames_closed++;

        bin_pos    = '0;
        peak_idx   = '0;
        runner_idx = '0;
        peak_mag   = '0;
        peak_live  = 1'b0;
    endtask

    // Receiver: random hold-off, none in quiet stretches, solid during a long hold
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else if (rx_hold)
            i_stall <= 1'b1;
        else if (quiet)
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(0, 99) < 15);
    end

    initial begin
        forever begin
            @(hold_start);
            rx_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_detector_report got;
        t_detector_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.kind         = o_kind;
            got.note_updated = o_note_updated;
            got.note         = o_note;
            got.note_seen    = o_note_seen;
            got.peak_bin     = o_peak_bin;
            got.beat_count   = o_beat_count;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing pending: kind %0d note %0d peak %0d",
                             $realtime, got.kind, got.note, got.peak_bin);
            end else begin
                want = pending_reports.pop_front();
                if (got.kind !== want.kind || got.note_updated !== want.note_updated
                        || got.note !== want.note || got.note_seen !== want.note_seen
                        || got.peak_bin !== want.peak_bin
                        || got.beat_count !== want.beat_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: mismatch exp/got kind %0d/%0d upd %0d/%0d note %0d/%0d ",
                                  "seen %0d/%0d peak %0d/%0d beats %0d/%0d"}, $realtime,
                                 want.kind, got.kind, want.note_updated, got.note_updated,
                                 want.note, got.note, want.note_seen, got.note_seen,
                                 want.peak_bin, got.peak_bin, want.beat_count, got.beat_count);
                end
            end
        end
    end

    // Valid stays high after a transfer; the next call either re-drives it or drops it
    task automatic send_item(input logic cmd, input logic [MAG_W-1:0] mag, input logic last);
        if (!quiet) begin
            while ($urandom_range(0, 99) < 15) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_magnitude <= mag;
        i_last_bin  <= last;
        do @(posedge i_clk); while (o_stall);
        track_item(cmd, mag, last);
        items_sent++;
        if (cmd == CMD_TICK)
            ticks_sent++;
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, 16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
    endtask

    task automatic maybe_tick();
        if ($urandom_range(0, 99) < 3)
            send_tick();
    endtask

    task automatic send_flat_frame(input int len, input logic [MAG_W-1:0] mag);
        int b;
        for (b = 0; b < len; b++)
            send_item(CMD_BIN, mag, b == len - 1);
    endtask

    task automatic pause_sender();
        i_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        pause_sender();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        swing_thr   = value;
        thr_writes++;
    endtask

    task automatic test_reset_tick();
        send_item(CMD_TICK, 16'hFFFF, 1'b1);
        send_item(CMD_TICK, 16'h0000, 1'b0);
        pause_sender();
    endtask

    task automatic test_directed_frames();
        int b;
        send_item(CMD_BIN, 16'h0000, 1'b1);
        send_item(CMD_BIN, 16'hFFFF, 1'b1);
        // equal maxima: the later bin wins
        send_item(CMD_BIN, 16'h1234, 1'b0);
        send_item(CMD_BIN, 16'h1234, 1'b0);
        send_item(CMD_BIN, 16'h0001, 1'b1);
        // tick in the middle of a frame leaves the frame alone
        send_item(CMD_BIN, 16'h0010, 1'b0);
        send_item(CMD_TICK, 16'h5555, 1'b1);
        send_item(CMD_BIN, 16'h0020, 1'b1);
        // peak on a pitch bin, replaced maximum far away: note taken
        for (b = 0; b < 25; b++)
            send_item(CMD_BIN, (b == 24) ? 16'hFFFF : (b == 0) ? 16'h0100 : 16'h0000,
                      b == 24);
        // replaced maximum next to the peak: note held
        for (b = 0; b < 25; b++)
            send_item(CMD_BIN, (b == 24) ? 16'h8000 : (b == 23) ? 16'h7000 : 16'h0000,
                      b == 24);
        // unmatched peak leaves the note alone
        send_item(CMD_BIN, 16'h0002, 1'b0);
        send_item(CMD_BIN, 16'h0003, 1'b0);
        send_item(CMD_BIN, 16'h0900, 1'b1);
        send_item(CMD_TICK, 16'h0000, 1'b0);
        pause_sender();
    endtask

    task automatic test_threshold_extremes();
        write_threshold('0);
        send_flat_frame(4, 16'h0400);
        send_flat_frame(2, 16'h0000);
        send_flat_frame(4, 16'h0400);
        send_flat_frame(1, 16'h0000);
        send_tick();
        write_threshold({THR_W{1'b1}});
        // one bin past the spectrum: position wraps, peak lands on bin 0 with bin 511 as runner-up,
        // and the sum saturates
        send_flat_frame(NUM_BINS + 1, 16'hFFFF);
        send_flat_frame(1, 16'h0000);
        send_tick();
        pause_sender();
    endtask

    task automatic test_backpressure();
        int i;
        write_threshold(THR_RESET);
        quiet = 1'b1;
        -> hold_start;
        for (i = 0; i < 40; i++) begin
            if (i % 3 == 0)
                send_tick();
            else
                send_item(CMD_BIN, 16'($urandom_range(0, 16'hFFFF)), 1'b1);
        end
        quiet = 1'b0;
        pause_sender();
    endtask

    task automatic send_note_frame();
        int               target;
        int               len;
        int               rival;
        int               style;
        int               b;
        logic [MAG_W-1:0] top;
        logic [MAG_W-1:0] mag;
        do begin
            target = ($urandom_range(0, 99) < 70) ? $urandom_range(24, 46)
                                                   : $urandom_range(47, 186);
        end while (pitch_class(target) < 0);
        len   = target + 1 + $urandom_range(0, 3);
        style = $urandom_range(0, 3);
        rival = (style == 0) ? target - 1 : (style == 1) ? target / 2 : -1;
        top   = 16'($urandom_range(16'h8000, 16'hFFFF));
        for (b = 0; b < len; b++) begin
            if (b == target)
                mag = top;
            else if (b == rival)
                mag = (style == 0) ? top - 16'($urandom_range(0, 255)) : top;
            else
                mag = 16'($urandom_range(0, 16'h3FFF));
            maybe_tick();
            send_item(CMD_BIN, mag, b == len - 1);
        end
    endtask

    task automatic send_noise_frame(input int min_len, input int max_len);
        int               len;
        int               b;
        int               pick;
        logic [MAG_W-1:0] mag;
        len = $urandom_range(min_len, max_len);
        for (b = 0; b < len; b++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                mag = '0;
            else if (pick == 1)
                mag = '1;
            else
                mag = 16'($urandom_range(0, 16'hFFFF));
            maybe_tick();
            send_item(CMD_BIN, mag, b == len - 1);
        end
    endtask

    task automatic test_random_traffic();
        int chunk;
        int target;
        int pick;
        for (chunk = 0; chunk < 4; chunk++) begin
            case (chunk)
                0: write_threshold(THR_W'($urandom_range(0, 16'hFFFF)));
                1: write_threshold('0);
                2: write_threshold(THR_W'($urandom_range(0, 24'h0FFFFF)));
                default: write_threshold(THR_RESET);
            endcase
            // hold both sides busy for the whole of one chunk
            quiet  = (chunk == 2);
            target = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    send_note_frame();
                else if (pick < 75)
                    send_noise_frame(1, 24);
                else if (pick < 90)
                    send_tick();
                else
                    send_noise_frame(25, 200);
            end
            quiet = 1'b0;
        end
        send_tick();
        pause_sender();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_tick();
        test_directed_frames();
        test_threshold_extremes();
        test_backpressure();
        test_random_traffic();
        pause_sender();

        $display("covered %0d transfers: %0d frames, %0d ticks, %0d note updates",
                 items_sent, frames_closed, ticks_sent, note_updates);
        $display("%0d beats read back over %0d threshold settings, %0d mismatches",
                 beats_read, thr_writes, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
